/* rtl/core/fixed_unit_pool_allocator_assert.svh */
// ============================================================================
// Assertion macros for the fixed unit pool allocator
// Shorthand for clocked properties sampled on clk with rst_n as disable.
// ============================================================================
`ifndef FIXED_UNIT_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_UNIT_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define FUPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FUPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fupa_pkg.sv */
// ============================================================================
// Fixed unit pool allocator package
// Shared widths, codes and the controller/datapath command and status types.
// ============================================================================
package fupa_pkg;

    localparam int MAX_BLOCKS_DEF = 8;
    localparam int MAX_UNITS_DEF  = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int SLOT_W    = 3;
    localparam int UNIT_W    = 8;
    localparam int STATUS_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_UNITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_UNITS = 1'b1;

    localparam logic [CFG_W-1:0] INIT_UNITS_RST = 9'd64;
    localparam logic [CFG_W-1:0] GROW_UNITS_RST = 9'd64;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC   = 3'd0,
        ST_FREED   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOSLOT  = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SETUP,
        OP_SWEEP,
        OP_CREATE,
        OP_READ,
        OP_ALLOC_FIN,
        OP_FREE,
        OP_REJECT
    } dp_op_t;

    typedef struct packed {
        logic   ready;
        dp_op_t op;
        logic   push;
    } cmd_t;

    typedef struct packed {
        logic req_valid;
        logic is_alloc;
        logic pool_empty;
        logic found_space;
        logic grow_zero;
        logic slot_avail;
        logic free_ok;
        logic sweep_last;
        logic out_busy;
    } stat_t;

endpackage

/* rtl/core/fupa_if.sv */
// ============================================================================
// Fixed unit pool allocator channels
// Request and response valid/ready channels with their payloads.
// ============================================================================
interface fupa_req_if;
    import fupa_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [SLOT_W-1:0] free_slot;
    logic [UNIT_W-1:0] free_unit;

    modport source (output valid, mode, free_slot, free_unit, input ready);
    modport sink   (input valid, mode, free_slot, free_unit, output ready);
endinterface

interface fupa_rsp_if;
    import fupa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   got_slot;
    logic [UNIT_W-1:0]   got_unit;

    modport source (output valid, status, got_slot, got_unit, input ready);
    modport sink   (input valid, status, got_slot, got_unit, output ready);
endinterface

/* rtl/core/fupa_ctrl.sv */
// ============================================================================
// Fixed unit pool allocator controller
// Sequences one request at a time through decide, sweep, create, fetch and emit.
// ============================================================================
module fupa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  fupa_pkg::stat_t stat,
    output fupa_pkg::cmd_t  cmd
);
    import fupa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SWEEP,
        S_CREATE,
        S_FETCH,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode state and datapath status into the next command
    always_comb
    begin
        state_next = state_reg;
        cmd.ready  = 1'b0;
        cmd.op     = OP_NONE;
        cmd.push   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (stat.req_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_alloc)
                begin
                    if (stat.pool_empty)
                    begin
                        cmd.op     = OP_SETUP;
                        state_next = S_SWEEP;
                    end
                    else if (stat.found_space)
                    begin
                        cmd.op     = OP_READ;
                        state_next = S_FETCH;
                    end
                    else if (stat.grow_zero || !stat.slot_avail)
                    begin
                        cmd.op     = OP_REJECT;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.op     = OP_SETUP;
                        state_next = S_SWEEP;
                    end
                end
                else
                begin
                    cmd.op     = stat.free_ok ? OP_FREE : OP_REJECT;
                    state_next = S_EMIT;
                end
            end
            S_SWEEP:
            begin
                cmd.op = OP_SWEEP;
                if (stat.sweep_last)
                begin
                    state_next = S_CREATE;
                end
            end
            S_CREATE:
            begin
                cmd.op     = OP_CREATE;
                state_next = S_EMIT;
            end
            S_FETCH:
            begin
                cmd.op     = OP_ALLOC_FIN;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/fupa_datapath.sv */
// ============================================================================
// Fixed unit pool allocator datapath
// Block table, search order, link memory, request and result registers.
// ============================================================================
module fupa_datapath #(
    parameter int MAX_BLOCKS = fupa_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_UNITS  = fupa_pkg::MAX_UNITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fupa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fupa_pkg::CFG_W-1:0]     cfg_data,
    fupa_req_if.sink                       req,
    fupa_rsp_if.source                     rsp,
    input  fupa_pkg::cmd_t                 cmd,
    output fupa_pkg::stat_t                stat
);
    import fupa_pkg::*;

    localparam int SW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int UW    = $clog2(MAX_UNITS);
    localparam int CW    = $clog2(MAX_UNITS + 1);
    localparam int LW    = $clog2(MAX_BLOCKS + 1);
    localparam int AW    = SW + UW;
    localparam int DEPTH = MAX_BLOCKS << UW;

    localparam logic [CW-1:0] UNITS_MAX = CW'(MAX_UNITS);
    localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_BLOCKS);

    // Take a size register into 1..MAX_UNITS
    function automatic logic [CW-1:0] clamp_units(input logic [CFG_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0)
        begin
            r = CW'(1);
        end
        else if (int'(v) > MAX_UNITS)
        begin
            r = UNITS_MAX;
        end
        else
        begin
            r = CW'(v);
        end
        return r;
    endfunction

    logic [CFG_W-1:0]  init_reg;
    logic [CFG_W-1:0]  grow_reg;

    logic              req_mode_reg;
    logic [SLOT_W-1:0] req_slot_reg;
    logic [UNIT_W-1:0] req_unit_reg;

    logic [CW-1:0]         free_count_reg [MAX_BLOCKS];
    logic [UW-1:0]         first_free_reg [MAX_BLOCKS];
    logic [CW-1:0]         units_reg      [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [SW-1:0]         order_reg      [MAX_BLOCKS];
    logic [LW-1:0]         len_reg;

    logic [SW-1:0] tgt_slot_reg;
    logic [UW-1:0] tgt_unit_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] sweep_reg;
    logic [UW-1:0] rdata_reg;

    status_t           res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [UNIT_W-1:0] res_unit_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [UNIT_W-1:0] out_unit_reg;

    logic [UW-1:0] link_mem [DEPTH];

    logic [MAX_BLOCKS-1:0] has_space;
    logic                  found_any;
    logic [SW-1:0]         found_slot;
    logic                  slot_any;
    logic [SW-1:0]         new_slot;
    logic                  slot_in_range;
    logic [SW-1:0]         rs;
    logic [UW-1:0]         ru;
    logic [SW-1:0]         rd_slot;
    logic [CW-1:0]         rd_count;
    logic [CW-1:0]         rd_units;
    logic [UW-1:0]         rd_first;
    logic                  pos_hit;
    logic [SW-1:0]         pos_idx;
    logic                  free_ok;
    logic [CW-1:0]         cnt_inc;
    logic                  free_all;
    logic [CW-1:0]         sweep_inc;
    logic                  sweep_last;
    logic                  load;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [UW-1:0]         mem_wdata;
    logic [AW-1:0]         rd_addr;

    assign load = req.valid && req.ready;
    assign req.ready = cmd.ready;

    // Flag blocks that still hold a free unit
    always_comb
    begin
        for (int s = 0; s < MAX_BLOCKS; s++)
        begin
            has_space[s] = (free_count_reg[s] != '0);
        end
    end

    // Find the first block in search order with space
    always_comb
    begin
        found_any  = 1'b0;
        found_slot = '0;
        for (int p = MAX_BLOCKS - 1; p >= 0; p--)
        begin
            if ((LW'(p) < len_reg) && has_space[order_reg[p]])
            begin
                found_any  = 1'b1;
                found_slot = order_reg[p];
            end
        end
    end

    // Find the lowest unused slot
    always_comb
    begin
        slot_any = 1'b0;
        new_slot = '0;
        for (int s = MAX_BLOCKS - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                slot_any = 1'b1;
                new_slot = SW'(s);
            end
        end
    end

    assign slot_in_range = (int'(req_slot_reg) < MAX_BLOCKS);
    assign rs            = SW'(req_slot_reg);
    assign ru            = UW'(req_unit_reg);

    // Select the block whose table entry the request reads
    assign rd_slot  = (req_mode_reg == MODE_ALLOC) ? found_slot : rs;
    assign rd_count = free_count_reg[rd_slot];
    assign rd_units = units_reg[rd_slot];
    assign rd_first = first_free_reg[rd_slot];

    // Locate the freed block in search order
    always_comb
    begin
        pos_hit = 1'b0;
        pos_idx = '0;
        for (int p = MAX_BLOCKS - 1; p >= 0; p--)
        begin
            if ((LW'(p) < len_reg) && (order_reg[p] == rs))
            begin
                pos_hit = 1'b1;
                pos_idx = SW'(p);
            end
        end
    end

    assign free_ok = slot_in_range && valid_reg[rs]
                     && (32'(req_unit_reg) < 32'(rd_units))
                     && (rd_count < rd_units) && pos_hit;
    assign cnt_inc  = rd_count + CW'(1);
    assign free_all = (cnt_inc == rd_units);

    assign sweep_inc  = sweep_reg + CW'(1);
    assign sweep_last = (sweep_inc == n_reg);

    always_comb
    begin
        stat.req_valid   = req.valid;
        stat.is_alloc    = (req_mode_reg == MODE_ALLOC);
        stat.pool_empty  = (len_reg == '0);
        stat.found_space = found_any;
        stat.grow_zero   = (grow_reg == '0);
        stat.slot_avail  = slot_any;
        stat.free_ok     = free_ok;
        stat.sweep_last  = sweep_last;
        stat.out_busy    = out_valid_reg && !rsp.ready;
    end

    // Drive the link memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = {tgt_slot_reg, sweep_reg[UW-1:0]};
        mem_wdata = sweep_last ? '0 : sweep_inc[UW-1:0];
        case (cmd.op)
            OP_SWEEP:
            begin
                mem_we = 1'b1;
            end
            OP_FREE:
            begin
                mem_we    = 1'b1;
                mem_addr  = {rs, ru};
                mem_wdata = rd_first;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign rd_addr = {found_slot, rd_first};

    // Link memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.op == OP_READ)
        begin
            rdata_reg <= link_mem[rd_addr];
        end
    end

    // Capture request beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_mode_reg <= req.mode;
            req_slot_reg <= req.free_slot;
            req_unit_reg <= req.free_unit;
        end
    end

    // Block table, search order and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= INIT_UNITS_RST;
            grow_reg  <= GROW_UNITS_RST;
            valid_reg <= '0;
            len_reg   <= '0;
            for (int s = 0; s < MAX_BLOCKS; s++)
            begin
                free_count_reg[s] <= '0;
                first_free_reg[s] <= '0;
                units_reg[s]      <= '0;
                order_reg[s]      <= '0;
            end
            tgt_slot_reg   <= '0;
            tgt_unit_reg   <= '0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            sweep_reg      <= '0;
            res_status_reg <= ST_ALLOC;
            res_slot_reg   <= '0;
            res_unit_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_INIT_UNITS)
                begin
                    init_reg <= cfg_data;
                end
                else if (cfg_index == CFG_GROW_UNITS)
                begin
                    grow_reg <= cfg_data;
                end
            end
            case (cmd.op)
                OP_SETUP:
                begin
                    tgt_slot_reg <= (len_reg == '0) ? '0 : new_slot;
                    n_reg        <= (len_reg == '0) ? clamp_units(init_reg)
                                                    : clamp_units(grow_reg);
                    sweep_reg    <= '0;
                end
                OP_SWEEP:
                begin
                    sweep_reg <= sweep_inc;
                end
                OP_CREATE:
                begin
                    units_reg[tgt_slot_reg]      <= n_reg;
                    free_count_reg[tgt_slot_reg] <= n_reg - CW'(1);
                    first_free_reg[tgt_slot_reg] <= UW'(1);
                    valid_reg[tgt_slot_reg]      <= 1'b1;
                    for (int i = MAX_BLOCKS - 1; i > 0; i--)
                    begin
                        order_reg[i] <= order_reg[i-1];
                    end
                    order_reg[0] <= tgt_slot_reg;
                    if (len_reg < LEN_MAX)
                    begin
                        len_reg <= len_reg + LW'(1);
                    end
                    res_status_reg <= ST_ALLOC;
                    res_slot_reg   <= SLOT_W'(tgt_slot_reg);
                    res_unit_reg   <= '0;
                end
                OP_READ:
                begin
                    tgt_slot_reg <= found_slot;
                    tgt_unit_reg <= rd_first;
                    cnt_reg      <= rd_count;
                end
                OP_ALLOC_FIN:
                begin
                    first_free_reg[tgt_slot_reg] <= rdata_reg;
                    free_count_reg[tgt_slot_reg] <= cnt_reg - CW'(1);
                    res_status_reg <= ST_ALLOC;
                    res_slot_reg   <= SLOT_W'(tgt_slot_reg);
                    res_unit_reg   <= UNIT_W'(tgt_unit_reg);
                end
                OP_FREE:
                begin
                    if (free_all && (pos_idx != '0))
                    begin
                        // Release a wholly free block unless it leads the order
                        for (int i = 0; i < MAX_BLOCKS - 1; i++)
                        begin
                            if (SW'(i) >= pos_idx)
                            begin
                                order_reg[i] <= order_reg[i+1];
                            end
                        end
                        order_reg[MAX_BLOCKS-1] <= '0;
                        len_reg            <= len_reg - LW'(1);
                        valid_reg[rs]      <= 1'b0;
                        free_count_reg[rs] <= '0;
                        first_free_reg[rs] <= '0;
                        units_reg[rs]      <= '0;
                    end
                    else
                    begin
                        first_free_reg[rs] <= ru;
                        free_count_reg[rs] <= cnt_inc;
                        if (!free_all)
                        begin
                            // Move the partly used block to the head
                            for (int i = 1; i < MAX_BLOCKS; i++)
                            begin
                                if (SW'(i) <= pos_idx)
                                begin
                                    order_reg[i] <= order_reg[i-1];
                                end
                            end
                            order_reg[0] <= rs;
                        end
                    end
                    res_status_reg <= ST_FREED;
                    res_slot_reg   <= '0;
                    res_unit_reg   <= '0;
                end
                OP_REJECT:
                begin
                    if (req_mode_reg == MODE_ALLOC)
                    begin
                        res_status_reg <= (grow_reg == '0) ? ST_FULL : ST_NOSLOT;
                    end
                    else
                    begin
                        res_status_reg <= ST_IGNORED;
                    end
                    res_slot_reg <= '0;
                    res_unit_reg <= '0;
                end
                default:
                begin
                    sweep_reg <= sweep_reg;
                end
            endcase
        end
    end

    // Output register: load on push, drop once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_unit_reg   <= res_unit_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.got_slot = out_slot_reg;
    assign rsp.got_unit = out_unit_reg;

endmodule

/* rtl/core/fixed_unit_pool_allocator.sv */
// ============================================================================
// Fixed unit pool allocator
// Requests take one at a time. A free goes from decide to emit, and an
// allocate from an existing block passes a fetch state between them for
// the registered read of the link memory. An allocate that creates a block
// of n units first writes the block's links into the link memory one entry
// per cycle. A result that is not taken holds the next request's result
// back, while the next request is still accepted.
// ============================================================================
module fixed_unit_pool_allocator #(
    parameter int MAX_BLOCKS = fupa_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_UNITS  = fupa_pkg::MAX_UNITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fupa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fupa_pkg::CFG_W-1:0]     cfg_data,
    fupa_req_if.sink                       req,
    fupa_rsp_if.source                     rsp
);
    import fupa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fupa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    fupa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_UNITS  (MAX_UNITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

`include "fixed_unit_pool_allocator_assert.svh"

    `FUPA_ASSERT_NOW(a_fail_zero_payload, rsp.valid && (rsp.status != ST_ALLOC), (rsp.got_slot == '0) && (rsp.got_unit == '0), "non-allocate result carries a slot or unit")
    `FUPA_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "request taken while one is in flight")
    `FUPA_ASSERT_NOW(a_status_code, rsp.valid, rsp.status <= ST_IGNORED, "status code out of range")

endmodule

/* dv/fixed_unit_pool_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed unit pool allocator testbench
// Drives allocate and free requests with random gaps and response stalls.
// A behavioral pool model predicts every response, and each response beat is
// compared field by field with the oldest prediction. Block sizes are
// reprogrammed between phases, including the extremes.
// ----------------------------------------------------------------------------
module fixed_unit_pool_allocator_tb;
    import fupa_pkg::*;

    localparam int NBLK  = MAX_BLOCKS_DEF;
    localparam int NUNIT = MAX_UNITS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [UNIT_W-1:0]   unit;
    } resp_t;

    typedef struct {
        logic             mode;
        logic [SLOT_W-1:0] slot;
        logic [UNIT_W-1:0] unit;
        bit               has_exp;
        status_t          exp_status;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    fupa_req_if req ();
    fupa_rsp_if rsp ();

    fixed_unit_pool_allocator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    // Pool model state
    int unsigned m_init, m_grow;
    int unsigned m_link [NBLK*NUNIT];
    int unsigned m_cnt [NBLK];
    int unsigned m_first [NBLK];
    int unsigned m_size [NBLK];
    bit          m_live [NBLK];
    int unsigned m_order [NBLK];
    int unsigned m_olen;

    resp_t pending_resp[$];
    int    errors;
    int    n_alloc, n_free, n_full, n_noslot, n_ignored, n_beats;

    // Track allocated units for well-formed frees
    typedef struct { int unsigned slot; int unsigned unit; } held_t;
    held_t held[$];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int unsigned clamp_size(int unsigned v);
        if (v == 0) return 1;
        if (v > NUNIT) return NUNIT;
        return v;
    endfunction

    task automatic build_block(int unsigned s, int unsigned n);
        for (int unsigned i = 1; i < n; i++)
            m_link[s*NUNIT + i - 1] = i;
        m_link[s*NUNIT + n - 1] = 0;
        m_size[s]  = n;
        m_cnt[s]   = n - 1;
        m_first[s] = 1;
        m_live[s]  = 1'b1;
        for (int unsigned i = m_olen; i > 0; i--)
            if (i < NBLK) m_order[i] = m_order[i-1];
        m_order[0] = s;
        if (m_olen < NBLK) m_olen++;
    endtask

    task automatic pool_reset();
        foreach (m_link[i]) m_link[i] = 0;
        for (int i = 0; i < NBLK; i++)
        begin
            m_cnt[i] = 0; m_first[i] = 0; m_size[i] = 0; m_live[i] = 0; m_order[i] = 0;
        end
        m_olen = 0;
        m_init = INIT_UNITS_RST;
        m_grow = GROW_UNITS_RST;
        held.delete();
    endtask

    // Predict one request and update the pool model
    task automatic pool_step(input logic mode, input int unsigned s, input int unsigned u,
                             output resp_t r);
        int unsigned p, i, sl, uu;
        r = '0;
        if (mode == MODE_ALLOC)
        begin
            if (m_olen == 0)
            begin
                build_block(0, clamp_size(m_init));
                r.status = ST_ALLOC;
                held.push_back('{0, 0});
                return;
            end
            for (p = 0; p < m_olen && p < NBLK; p++)
            begin
                sl = m_order[p] % NBLK;
                if (m_cnt[sl] != 0)
                begin
                    uu = m_first[sl];
                    m_first[sl] = m_link[sl*NUNIT + uu];
                    m_cnt[sl]--;
                    r.status = ST_ALLOC; r.slot = sl; r.unit = uu;
                    held.push_back('{sl, uu});
                    return;
                end
            end
            if (m_grow == 0)
            begin
                r.status = ST_FULL;
                return;
            end
            for (sl = 0; sl < NBLK; sl++)
                if (!m_live[sl]) break;
            if (sl >= NBLK)
            begin
                r.status = ST_NOSLOT;
                return;
            end
            build_block(sl, clamp_size(m_grow));
            r.status = ST_ALLOC; r.slot = sl;
            held.push_back('{sl, 0});
            return;
        end
        r.status = ST_IGNORED;
        if (s >= NBLK || !m_live[s]) return;
        if (u >= m_size[s] || m_cnt[s] >= m_size[s]) return;
        for (p = 0; p < m_olen; p++)
            if (m_order[p] == s) break;
        if (p >= m_olen) return;
        m_link[s*NUNIT + u] = m_first[s];
        m_first[s] = u;
        m_cnt[s]++;
        r.status = ST_FREED;
        if (m_cnt[s] == m_size[s])
        begin
            if (p != 0)
            begin
                for (i = p; i + 1 < m_olen; i++)
                    m_order[i] = m_order[i+1];
                m_olen--;
                m_order[m_olen] = 0;
                m_live[s] = 0; m_cnt[s] = 0; m_first[s] = 0; m_size[s] = 0;
                for (int k = held.size() - 1; k >= 0; k--)
                    if (held[k].slot == s) held.delete(k);
            end
        end
        else
        begin
            for (i = p; i > 0; i--)
                m_order[i] = m_order[i-1];
            m_order[0] = s;
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    bit no_stall;

    // Send one request beat and queue its prediction; hold valid across a zero gap
    task automatic send_req(input logic mode, input int unsigned s, input int unsigned u,
                            input bit chk, input status_t want);
        resp_t r;
        int g;
        g = no_stall ? 0 : gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.mode      <= mode;
        req.free_slot <= s[SLOT_W-1:0];
        req.free_unit <= u[UNIT_W-1:0];
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        pool_step(mode, s, u, r);
        if (chk && r.status != want)
        begin
            $display("%0t: directed row predicts status %0d, table says %0d",
                     $time, r.status, want);
            errors++;
        end
        pending_resp.push_back(r);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_INIT_UNITS) m_init = v; else m_grow = v;
    endtask

    // Drop the request, wait for all results, then for the longest block build
    task automatic drain();
        req.valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge clk);
        repeat (NUNIT + 20) @(posedge clk);
    endtask

    // Response side: random stall, compare each beat
    always @(negedge clk)
        rsp.ready <= (!rst_n) ? 1'b0 : (no_stall ? 1'b1 : ($urandom_range(0, 3) != 0));

    always @(posedge clk)
    begin
        resp_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            n_beats++;
            if (pending_resp.size() == 0)
            begin
                $display("%0t: unexpected beat status=%0d slot=%0d unit=%0d",
                         $time, rsp.status, rsp.got_slot, rsp.got_unit);
                errors++;
            end
            else
            begin
                exp_r = pending_resp.pop_front();
                case (exp_r.status)
                    ST_ALLOC:   n_alloc++;
                    ST_FREED:   n_free++;
                    ST_FULL:    n_full++;
                    ST_NOSLOT:  n_noslot++;
                    default:    n_ignored++;
                endcase
                if (rsp.status !== exp_r.status || rsp.got_slot !== exp_r.slot ||
                    rsp.got_unit !== exp_r.unit)
                begin
                    $display("%0t: mismatch expected status=%0d slot=%0d unit=%0d, got status=%0d slot=%0d unit=%0d",
                             $time, exp_r.status, exp_r.slot, exp_r.unit,
                             rsp.status, rsp.got_slot, rsp.got_unit);
                    errors++;
                end
            end
        end
    end

    // Random phase: mostly alloc/free of held units, some noise frees
    task automatic random_phase(int count);
        int k, r;
        held_t h;
        for (int n = 0; n < count; n++)
        begin
            no_stall = (n % 200) < 20;
            r = $urandom_range(0, 99);
            if (r < 50 || held.size() == 0)
                send_req(MODE_ALLOC, $urandom, $urandom, 0, ST_ALLOC);
            else if (r < 90)
            begin
                k = $urandom_range(0, held.size() - 1);
                h = held[k];
                held.delete(k);
                send_req(MODE_FREE, h.slot, h.unit, 0, ST_ALLOC);
            end
            else
                send_req(MODE_FREE, $urandom_range(0, 7), $urandom_range(0, 255), 0, ST_ALLOC);
        end
        no_stall = 0;
    endtask

    row_t dir_rows[$];

    initial
    begin
        errors = 0; n_alloc = 0; n_free = 0; n_full = 0; n_noslot = 0; n_ignored = 0;
        n_beats = 0; no_stall = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_INIT_UNITS; cfg_data = '0;
        req.valid = 1'b0; req.mode = MODE_ALLOC; req.free_slot = '0; req.free_unit = '0;
        rsp.ready = 1'b0;
        pool_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: tiny blocks so full, no-slot and release cases come quickly
        write_reg(CFG_INIT_UNITS, 0);
        write_reg(CFG_GROW_UNITS, 1);
        dir_rows = '{
            '{MODE_FREE,  3'd0, 8'd0,   1, ST_IGNORED},  // free with no blocks
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},    // first block, size clamped to one
            '{MODE_FREE,  3'd0, 8'd1,   1, ST_IGNORED},  // unit beyond block size
            '{MODE_FREE,  3'd7, 8'd255, 1, ST_IGNORED},  // slot never created
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_ALLOC},    // all eight slots used
            '{MODE_ALLOC, 3'd0, 8'd0,   1, ST_NOSLOT},
            '{MODE_FREE,  3'd3, 8'd0,   1, ST_FREED},    // non-head empties, released
            '{MODE_FREE,  3'd3, 8'd0,   1, ST_IGNORED},
            '{MODE_ALLOC, 3'd0, 8'd0,   0, ST_ALLOC},
            '{MODE_FREE,  3'd7, 8'd0,   1, ST_FREED},
            '{MODE_FREE,  3'd0, 8'd0,   0, ST_ALLOC}
        };
        foreach (dir_rows[i])
            send_req(dir_rows[i].mode, dir_rows[i].slot, dir_rows[i].unit,
                     dir_rows[i].has_exp, dir_rows[i].exp_status);
        drain();
        write_reg(CFG_GROW_UNITS, 0);
        send_req(MODE_ALLOC, 0, 0, 0, ST_ALLOC);
        for (int i = 0; i < 8; i++)
            send_req(MODE_ALLOC, 0, 0, 0, ST_ALLOC);
        drain();

        // Random phases over several block size settings
        write_reg(CFG_GROW_UNITS, 3);
        random_phase(300);
        drain();
        write_reg(CFG_GROW_UNITS, 0);
        random_phase(200);
        drain();
        write_reg(CFG_INIT_UNITS, 511);
        write_reg(CFG_GROW_UNITS, 256);
        random_phase(150);
        drain();
        write_reg(CFG_INIT_UNITS, 256);
        write_reg(CFG_GROW_UNITS, 2);
        random_phase(300);
        drain();
        write_reg(CFG_GROW_UNITS, 5);
        random_phase(400);
        drain();
        write_reg(CFG_GROW_UNITS, 384);
        random_phase(200);
        drain();

        $display("Covered %0d beats: %0d alloc, %0d freed, %0d full, %0d no-slot, %0d ignored",
                 n_beats, n_alloc, n_free, n_full, n_noslot, n_ignored);
        if (errors == 0)
            $display("fixed_unit_pool_allocator_tb: PASS");
        else
            $display("fixed_unit_pool_allocator_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40ms;
        $display("fixed_unit_pool_allocator_tb: FAIL");
        $finish;
    end
endmodule
